// ===== hw/rtl/jade_pkg.sv =====
package jade_pkg;

   // field widths
   localparam int SAMPLE_W = 8;
   localparam int CHAR_W   = 8;
   localparam int DIGIT_W  = 4;

   // calibration
   localparam int CALIBRATION_SAMPLES = 10;
   localparam int CAL_W = 4;
   localparam logic [CAL_W-1:0] CAL_TARGET = CAL_W'(CALIBRATION_SAMPLES);
   localparam logic [CAL_W-1:0] CAL_DONE   = CAL_W'(CALIBRATION_SAMPLES + 1);

   // remap constants
   localparam logic [SAMPLE_W-1:0] MID_VALUE = 8'd128;
   localparam logic [SAMPLE_W-1:0] MAX_VALUE = 8'd255;
   localparam int FRAC_SHIFT = 7;

   // serial divider geometry: |d| * 128 over an 8-bit range
   localparam int DIV_NUM_W = SAMPLE_W + FRAC_SHIFT;
   localparam int DIV_DEN_W = SAMPLE_W;
   localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_NUM_W - 1);

   // serial binary to bcd geometry
   localparam int BCD_DIGITS = 3;
   localparam int BCD_CNT_W  = $clog2(SAMPLE_W);
   localparam logic [BCD_CNT_W-1:0] BCD_LAST = BCD_CNT_W'(SAMPLE_W - 1);

   // characters
   localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'd32;
   localparam logic [CHAR_W-1:0] CHAR_CR    = 8'd13;

   // register file
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;
   localparam logic CSR_IDX_REMAP_ENABLE = 1'b0;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALIB,
      ST_SETUP,
      ST_DIV,
      ST_CONV,
      ST_DIGITS,
      ST_EMIT
   } jade_state_type;

   typedef enum logic [1:0] {
      SLOT_HUND,
      SLOT_TENS,
      SLOT_ONES,
      SLOT_SEP
   } jade_slot_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] hund;
      logic [DIGIT_W-1:0] tens;
      logic [DIGIT_W-1:0] ones;
   } jade_digits_type;

   typedef struct packed {
      logic                 done;
      logic [DIV_NUM_W-1:0] quot;
      logic                 rem_nz;
   } jade_div_res_type;

endpackage

// ===== hw/rtl/jade_ifs.sv =====
interface jade_req_if import jade_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] x_sample;
   logic [SAMPLE_W-1:0] y_sample;

   modport source (output valid, output x_sample, output y_sample, input ready);
   modport sink   (input valid, input x_sample, input y_sample, output ready);
endinterface

interface jade_rsp_if import jade_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [CHAR_W-1:0] out_char;
   logic              last_char;

   modport source (output valid, output out_char, output last_char, input ready);
   modport sink   (input valid, input out_char, input last_char, output ready);
endinterface

// ===== hw/rtl/joystick_autocal_decimal_emitter.sv =====
// Joystick sample to ASCII line emitter. Each accepted beat carries one X and
// one Y sample and yields one line on the result channel: X in decimal without
// leading zeros, a space, Y in decimal, then a carriage return with last_char
// set (4 to 8 beats). With remap_enable set (register 0, bit 0) the block also
// tracks min/max per axis, latches the centers on the tenth remapped beat and
// remaps each axis piecewise-linearly around its center to 0..255. With
// remapping, an axis that is off its center with a nonempty range goes
// through a bit-serial divider (one quotient bit a cycle); in both modes
// each axis then goes through a serial binary-to-BCD converter, and the
// characters leave from a single output register, at most one per cycle
// and held by any output stall. The next beat is taken as soon as the carriage return sits in that register.
module joystick_autocal_decimal_emitter import jade_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   jade_req_if.sink              req_chan,
   jade_rsp_if.source            rsp_chan,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   jade_state_type      state_ff, state_in;
   jade_slot_type       slot_ff;
   logic                axis_ff;
   logic                remap_ff;
   logic [CAL_W-1:0]    cal_cnt_ff;
   logic [SAMPLE_W-1:0] smp_ff [2];
   logic [SAMPLE_W-1:0] val_ff [2];
   logic [SAMPLE_W-1:0] min_ff [2];
   logic [SAMPLE_W-1:0] ctr_ff [2];
   logic [SAMPLE_W-1:0] max_ff [2];
   logic                neg_ff;
   logic                rsp_valid_ff;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic                rsp_last_ff;

   // register access
   logic csr_hit;
   assign csr_hit    = (csr_paddr[CSR_ADDR_W-1:2] == CSR_IDX_REMAP_ENABLE);
   assign csr_pready = 1'b1;
   assign csr_prdata = csr_hit ? {{(CSR_DATA_W-1){1'b0}}, remap_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         remap_ff <= 1'b0;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         remap_ff <= csr_pwdata[0];
      end
   end

   logic accept;
   assign accept = req_chan.valid && req_chan.ready;

   // calibration update for both axes
   logic [CAL_W-1:0]    cal_inc;
   logic                capture;
   logic [CAL_W-1:0]    cal_cnt_in;
   logic [SAMPLE_W-1:0] ctr_in [2];
   logic [SAMPLE_W-1:0] min_in [2];
   logic [SAMPLE_W-1:0] max_in [2];

   always_comb begin
      cal_inc    = (cal_cnt_ff < CAL_TARGET) ? cal_cnt_ff + 1'b1 : cal_cnt_ff;
      capture    = (cal_inc == CAL_TARGET);
      cal_cnt_in = capture ? CAL_DONE : cal_inc;
      for (int a = 0; a < 2; a++) begin
         ctr_in[a] = capture ? smp_ff[a] : ctr_ff[a];
         min_in[a] = min_ff[a];
         max_in[a] = max_ff[a];
         if (smp_ff[a] < min_ff[a])
            min_in[a] = smp_ff[a];
         else if (smp_ff[a] > max_ff[a])
            max_in[a] = smp_ff[a];
      end
   end

   // offset and range of the current axis
   logic [SAMPLE_W-1:0] cur_v;
   logic [SAMPLE_W-1:0] cur_c;
   logic                above;
   logic [SAMPLE_W-1:0] mag;
   logic [SAMPLE_W:0]   rng;
   logic                degen;

   always_comb begin
      cur_v = smp_ff[axis_ff];
      cur_c = ctr_ff[axis_ff];
      above = cur_v > cur_c;
      mag   = above ? cur_v - cur_c : cur_c - cur_v;
      rng   = above ? {1'b0, max_ff[axis_ff]} - {1'b0, cur_c}
                    : {1'b0, cur_c} - {1'b0, min_ff[axis_ff]};
      degen = (cur_v == cur_c) || rng[SAMPLE_W] || (rng == '0);
   end

   // divider and bcd units
   logic             div_start;
   jade_div_res_type div_res;
   logic             bcd_start;
   logic             bcd_done;
   jade_digits_type  digits;

   jade_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   ({mag, {FRAC_SHIFT{1'b0}}}),
      .den   (rng[SAMPLE_W-1:0]),
      .res   (div_res)
   );

   jade_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .start  (bcd_start),
      .value  (val_ff[axis_ff]),
      .done   (bcd_done),
      .digits (digits)
   );

   // quotient to remapped value, floor below center, clamp both ends
   logic [DIV_NUM_W:0]  q_ceil;
   logic [SAMPLE_W-1:0] remap_val;

   always_comb begin
      q_ceil = {1'b0, div_res.quot} + {{DIV_NUM_W{1'b0}}, div_res.rem_nz};
      if (neg_ff)
         remap_val = (q_ceil > (DIV_NUM_W+1)'(MID_VALUE)) ? '0
                     : MID_VALUE - q_ceil[SAMPLE_W-1:0];
      else
         remap_val = (div_res.quot > DIV_NUM_W'(MID_VALUE - 1'b1)) ? MAX_VALUE
                     : MID_VALUE + {1'b0, div_res.quot[SAMPLE_W-2:0]};
   end

   // character slot decode
   logic              can_load;
   logic              skip;
   logic [CHAR_W-1:0] slot_char;
   logic              slot_last;
   logic              advance;
   logic              load;

   assign can_load = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      skip      = 1'b0;
      slot_last = 1'b0;
      slot_char = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits.ones};
      case (slot_ff)
         SLOT_HUND: begin
            skip      = (digits.hund == '0);
            slot_char = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits.hund};
         end
         SLOT_TENS: begin
            skip      = (digits.hund == '0) && (digits.tens == '0);
            slot_char = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits.tens};
         end
         SLOT_ONES: begin
            slot_char = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits.ones};
         end
         default: begin
            slot_char = axis_ff ? CHAR_CR : CHAR_SPACE;
            slot_last = axis_ff;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = remap_ff ? ST_CALIB : ST_CONV;
         ST_CALIB:  state_in = ST_SETUP;
         ST_SETUP:  state_in = degen ? (axis_ff ? ST_CONV : ST_SETUP) : ST_DIV;
         ST_DIV:    if (div_res.done) state_in = axis_ff ? ST_CONV : ST_SETUP;
         ST_CONV:   state_in = ST_DIGITS;
         ST_DIGITS: if (bcd_done) state_in = ST_EMIT;
         ST_EMIT:   if (advance && slot_ff == SLOT_SEP)
                       state_in = axis_ff ? ST_IDLE : ST_CONV;
         default:   state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_chan.ready = 1'b0;
      div_start      = 1'b0;
      bcd_start      = 1'b0;
      advance        = 1'b0;
      load           = 1'b0;
      unique case (state_ff)
         ST_IDLE:  req_chan.ready = 1'b1;
         ST_SETUP: div_start = !degen;
         ST_CONV:  bcd_start = 1'b1;
         ST_EMIT: begin
            advance = skip || can_load;
            load    = !skip && can_load;
         end
         default: ;
      endcase
   end

   logic axis_flip;
   assign axis_flip = (state_ff == ST_SETUP && degen)
                   || (state_ff == ST_DIV && div_res.done)
                   || (state_ff == ST_EMIT && advance && slot_ff == SLOT_SEP);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         slot_ff      <= SLOT_HUND;
         axis_ff      <= 1'b0;
         cal_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < 2; a++) begin
            min_ff[a] <= MID_VALUE;
            ctr_ff[a] <= MID_VALUE;
            max_ff[a] <= MID_VALUE;
         end
      end else begin
         state_ff <= state_in;
         if (axis_flip)
            axis_ff <= !axis_ff;
         if (state_ff == ST_CALIB) begin
            cal_cnt_ff <= cal_cnt_in;
            for (int a = 0; a < 2; a++) begin
               min_ff[a] <= min_in[a];
               ctr_ff[a] <= ctr_in[a];
               max_ff[a] <= max_in[a];
            end
         end
         if (advance) begin
            case (slot_ff)
               SLOT_HUND: slot_ff <= SLOT_TENS;
               SLOT_TENS: slot_ff <= SLOT_ONES;
               SLOT_ONES: slot_ff <= SLOT_SEP;
               default:   slot_ff <= SLOT_HUND;
            endcase
         end
         if (load)
            rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         smp_ff[0] <= req_chan.x_sample;
         smp_ff[1] <= req_chan.y_sample;
         val_ff[0] <= req_chan.x_sample;
         val_ff[1] <= req_chan.y_sample;
      end
      if (state_ff == ST_SETUP && !degen)
         neg_ff <= !above;
      if (state_ff == ST_SETUP && degen)
         val_ff[axis_ff] <= MID_VALUE;
      else if (state_ff == ST_DIV && div_res.done)
         val_ff[axis_ff] <= remap_val;
      if (load) begin
         rsp_char_ff <= slot_char;
         rsp_last_ff <= slot_last;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.out_char  = rsp_char_ff;
   assign rsp_chan.last_char = rsp_last_ff;

endmodule

// ===== hw/rtl/jade_div.sv =====
module jade_div import jade_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [DIV_NUM_W-1:0] num,
   input  logic [DIV_DEN_W-1:0] den,
   output jade_div_res_type     res
);

   logic [DIV_DEN_W-1:0] rem_ff;
   logic [DIV_NUM_W-1:0] quo_ff;
   logic [DIV_DEN_W-1:0] den_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [DIV_DEN_W:0]   trial;
   logic [DIV_DEN_W:0]   diff;
   logic                 fits;
   logic [DIV_DEN_W-1:0] rem_in;

   // one restoring step per cycle, numerator bits shift out the top
   always_comb begin
      trial  = {rem_ff, quo_ff[DIV_NUM_W-1]};
      diff   = trial - {1'b0, den_ff};
      fits   = trial >= {1'b0, den_ff};
      rem_in = fits ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == DIV_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= num;
         den_ff <= den;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         quo_ff <= {quo_ff[DIV_NUM_W-2:0], fits};
      end
   end

   assign res.done   = done_ff;
   assign res.quot   = quo_ff;
   assign res.rem_nz = (rem_ff != '0);

endmodule

// ===== hw/rtl/jade_bcd.sv =====
module jade_bcd import jade_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [SAMPLE_W-1:0] value,
   output logic                done,
   output jade_digits_type     digits
);

   logic [SAMPLE_W-1:0]           bin_ff;
   logic [BCD_DIGITS*DIGIT_W-1:0] bcd_ff;
   logic [BCD_CNT_W-1:0]          cnt_ff;
   logic                          busy_ff;
   logic                          done_ff;

   logic [BCD_DIGITS*DIGIT_W-1:0] adj;

   // add-3 correction on each bcd digit before the shift
   always_comb begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
         if (bcd_ff[i*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5))
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
         else
            adj[i*DIGIT_W +: DIGIT_W] = bcd_ff[i*DIGIT_W +: DIGIT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == BCD_LAST) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // one binary bit enters the bcd word per cycle
   always_ff @(posedge clock) begin
      if (start) begin
         bin_ff <= value;
         bcd_ff <= '0;
      end else if (busy_ff) begin
         bin_ff <= {bin_ff[SAMPLE_W-2:0], 1'b0};
         bcd_ff <= {adj[BCD_DIGITS*DIGIT_W-2:0], bin_ff[SAMPLE_W-1]};
      end
   end

   assign done   = done_ff;
   assign digits = bcd_ff;

endmodule

// ===== hw/rtl/jade_checker.sv =====
module jade_checker import jade_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [CHAR_W-1:0] rsp_out_char,
   input logic              rsp_last_char
);

   // one line at a time: a taken sample beat is followed by a busy cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken back to back");

   // a stalled result beat holds its character
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_char)
                                  && $stable(rsp_last_char))
      else $error("result beat changed while stalled");

   // end of line is always a carriage return
   a_last_is_cr: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_char |-> rsp_out_char == CHAR_CR)
      else $error("last beat is not a carriage return");

   // every other beat is a digit or the separating space
   a_body_chars: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_char |->
         (rsp_out_char == CHAR_SPACE)
         || (rsp_out_char >= CHAR_ZERO && rsp_out_char <= CHAR_ZERO + 8'd9))
      else $error("unexpected character in line body");

endmodule

bind joystick_autocal_decimal_emitter jade_checker u_jade_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_chan.valid),
   .req_ready     (req_chan.ready),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .rsp_out_char  (rsp_chan.out_char),
   .rsp_last_char (rsp_chan.last_char)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import jade_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 80;
   localparam int MAX_REPORTS = 10;
   localparam logic [CSR_ADDR_W-1:0] REMAP_ADDR = CSR_ADDR_W'(4 * int'(CSR_IDX_REMAP_ENABLE));
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = CSR_ADDR_W'(4);

   typedef struct packed {
      logic [CHAR_W-1:0] chr;
      logic              last;
   } char_beat_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   jade_req_if req_bus ();
   jade_rsp_if rsp_bus ();

   joystick_autocal_decimal_emitter i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predicted block state
   logic [SAMPLE_W-1:0] axis_lim [6];
   logic [CAL_W-1:0]    cal_cnt;
   logic                remap_on;

   char_beat_type pending_chars [$];
   int  err_count;
   int  sample_count;
   int  remap_count;
   int  char_count;
   int  cycle_count;
   int  rsp_stall;
   bit  steady_flow;

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // gap length: mostly none or short, now and then long
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(4, 24);
   endfunction

   task automatic report_error(input string msg);
      err_count++;
      if (err_count <= MAX_REPORTS) begin
         $display("ERROR @%0t: %s", $realtime, msg);
      end
   endtask

   // piecewise-linear remap of one axis, updates its min/max
   function automatic logic [SAMPLE_W-1:0] scale_axis(input int axis,
                                                      input logic [SAMPLE_W-1:0] v);
      int base;
      int ctr;
      int lo;
      int hi;
      int delta;
      int span;
      int num;
      int quo;
      int res;
      base = axis * 3;
      if (v < axis_lim[base]) begin
         axis_lim[base] = v;
      end else if (v > axis_lim[base+2]) begin
         axis_lim[base+2] = v;
      end
      lo    = int'(axis_lim[base]);
      ctr   = int'(axis_lim[base+1]);
      hi    = int'(axis_lim[base+2]);
      delta = int'(v) - ctr;
      if (delta == 0) return MID_VALUE;
      span = (delta > 0) ? (hi - ctr) : (ctr - lo);
      // guarded zero range
      if (span <= 0) return MID_VALUE;
      num = delta * 128;
      if (num >= 0) begin
         quo = num / span;
      end else begin
         quo = -((-num + span - 1) / span);
      end
      res = 128 + quo;
      if (res > 255) res = 255;
      if (res < 0) res = 0;
      return res[SAMPLE_W-1:0];
   endfunction

   function automatic void push_char(input logic [CHAR_W-1:0] c, input logic lst);
      char_beat_type b;
      b.chr  = c;
      b.last = lst;
      pending_chars.push_back(b);
   endfunction

   // decimal digits without leading zeros
   function automatic void push_decimal(input logic [SAMPLE_W-1:0] v);
      int h;
      int t;
      int o;
      h = v / 100;
      t = (v / 10) % 10;
      o = v % 10;
      if (h != 0) push_char(CHAR_ZERO + CHAR_W'(h), 1'b0);
      if (h != 0 || t != 0) push_char(CHAR_ZERO + CHAR_W'(t), 1'b0);
      push_char(CHAR_ZERO + CHAR_W'(o), 1'b0);
   endfunction

   // expected line for one accepted sample pair
   function automatic void predict_line(input logic [SAMPLE_W-1:0] x,
                                        input logic [SAMPLE_W-1:0] y);
      logic [SAMPLE_W-1:0] xv;
      logic [SAMPLE_W-1:0] yv;
      xv = x;
      yv = y;
      if (remap_on) begin
         if (cal_cnt < CAL_TARGET) cal_cnt = cal_cnt + 1'b1;
         // center capture, counter then parks past the target
         if (cal_cnt == CAL_TARGET) begin
            axis_lim[1] = x;
            axis_lim[4] = y;
            cal_cnt = CAL_DONE;
         end
         xv = scale_axis(0, x);
         yv = scale_axis(1, y);
      end
      push_decimal(xv);
      push_char(CHAR_SPACE, 1'b0);
      push_decimal(yv);
      push_char(CHAR_CR, 1'b1);
   endfunction

   // one sample beat, valid stays high after acceptance
   task automatic send_sample(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y);
      int gap;
      gap = steady_flow ? 0 : idle_len();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid    <= 1'b1;
      req_bus.x_sample <= x;
      req_bus.y_sample <= y;
      @(posedge clock);
      while (!(req_bus.valid && req_bus.ready)) @(posedge clock);
      predict_line(x, y);
      sample_count++;
      if (remap_on) remap_count++;
   endtask

   // drop valid and wait for every expected character
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pending_chars.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // apb setup and access phases, then idle with psel low
   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= addr;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   // write remap_enable, then read it back
   task automatic set_remap(input logic [CSR_DATA_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, REMAP_ADDR, value, rd);
      remap_on = value[0];
      csr_access(1'b0, REMAP_ADDR, '0, rd);
      if (rd[0] !== remap_on) begin
         report_error($sformatf("remap_enable readback exp %0b act %0b", remap_on, rd[0]));
      end
   endtask

   // raw mode: digit counts, extremes and alternating bits
   task automatic test_raw_extremes();
      steady_flow = 1'b0;
      send_sample(8'd0, 8'd0);
      send_sample(8'd255, 8'd255);
      send_sample(8'd9, 8'd10);
      send_sample(8'd99, 8'd100);
      send_sample(8'd128, 8'd7);
      send_sample(8'hAA, 8'h55);
      send_sample(8'h55, 8'hAA);
      settle();
   endtask

   // ignored index, only bit 0 of the value counts
   task automatic test_register_access();
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, SPARE_ADDR, '1, rd);
      csr_access(1'b0, REMAP_ADDR, '0, rd);
      if (rd[0] !== remap_on) begin
         report_error($sformatf("remap_enable after spare write exp %0b act %0b",
                                remap_on, rd[0]));
      end
      set_remap(32'hFFFF_FFFE);
      steady_flow = 1'b1;
      send_sample(8'd201, 8'd37);
      settle();
   endtask

   // calibration: pre-capture remap, capture, full scale, floor, saturation
   task automatic test_calibration_sequence();
      logic [SAMPLE_W-1:0] xs [14];
      logic [SAMPLE_W-1:0] ys [14];
      xs = '{8'd128, 8'd0, 8'd255, 8'd101, 8'd102, 8'd103, 8'd104, 8'd105, 8'd106,
             8'd60, 8'd60, 8'd255, 8'd0, 8'd61};
      ys = '{8'd128, 8'd255, 8'd0, 8'd150, 8'd151, 8'd152, 8'd20, 8'd30, 8'd40,
             8'd200, 8'd200, 8'd255, 8'd0, 8'd199};
      set_remap(32'hFFFF_FFFF);
      steady_flow = 1'b0;
      foreach (xs[i]) send_sample(xs[i], ys[i]);
      settle();
   endtask

   // pick an axis value biased toward the interesting points
   function automatic logic [SAMPLE_W-1:0] pick_axis(input int axis);
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return 8'd0;
      if (r < 16) return 8'd255;
      if (r < 28) return axis_lim[axis*3+1];
      if (r < 34) return axis_lim[axis*3];
      if (r < 40) return axis_lim[axis*3+2];
      if (r < 55) return axis_lim[axis*3+1] + SAMPLE_W'($urandom_range(0, 6)) - 8'd3;
      return SAMPLE_W'($urandom_range(0, 255));
   endfunction

   task automatic test_random_samples(input logic [CSR_DATA_W-1:0] mode, input int count);
      set_remap(mode);
      for (int i = 0; i < count; i++) begin
         if (i % 30 == 0) steady_flow = ($urandom_range(0, 3) == 0);
         send_sample(pick_axis(0), pick_axis(1));
      end
      settle();
   endtask

   // result side: random stalls unless the flow is steady
   initial begin
      rsp_bus.ready <= 1'b0;
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (steady_flow) begin
            rsp_bus.ready <= 1'b1;
         end else if (rsp_stall > 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_stall--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if ($urandom_range(0, 3) == 0) rsp_stall = idle_len();
         end
      end
   end

   // compare each character beat with the oldest expectation
   always @(posedge clock) begin
      char_beat_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         char_count++;
         if (pending_chars.size() == 0) begin
            report_error($sformatf("unexpected char 0x%02h last %0b",
                                   rsp_bus.out_char, rsp_bus.last_char));
         end else begin
            want = pending_chars.pop_front();
            if (rsp_bus.out_char !== want.chr || rsp_bus.last_char !== want.last) begin
               report_error($sformatf("char exp 0x%02h last %0b, act 0x%02h last %0b",
                                      want.chr, want.last,
                                      rsp_bus.out_char, rsp_bus.last_char));
            end
         end
      end
   end

   // runaway guard
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("joystick_autocal_decimal_emitter test failed");
         $finish;
      end
   end

   // main sequence
   initial begin
      reset            <= 1'b1;
      req_bus.valid    <= 1'b0;
      req_bus.x_sample <= '0;
      req_bus.y_sample <= '0;
      csr_psel         <= 1'b0;
      csr_penable      <= 1'b0;
      csr_pwrite       <= 1'b0;
      csr_paddr        <= '0;
      csr_pwdata       <= '0;
      for (int i = 0; i < 6; i++) axis_lim[i] = MID_VALUE;
      cal_cnt      = '0;
      remap_on     = 1'b0;
      err_count    = 0;
      sample_count = 0;
      remap_count  = 0;
      char_count   = 0;
      cycle_count  = 0;
      steady_flow  = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_raw_extremes();
      test_register_access();
      test_calibration_sequence();
      test_random_samples(32'd1, 100);
      test_random_samples(32'd0, 60);
      test_random_samples(32'h8000_0001, 90);
      test_random_samples(32'hFFFF_FFF0, 30);
      test_random_samples(32'd1, 30);

      // let any stray character show up
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0) begin
         report_error($sformatf("%0d expected chars never arrived", pending_chars.size()));
      end

      $display("sent %0d sample pairs (%0d remapped), checked %0d characters",
               sample_count, remap_count, char_count);
      $display("errors: %0d", err_count);
      if (err_count == 0) begin
         $display("joystick_autocal_decimal_emitter test passed");
      end else begin
         $display("joystick_autocal_decimal_emitter test failed");
      end
      $finish;
   end

endmodule
